// ----- rtl/grip_force_contact_guard_assert.svh -----
// Assertion macros for the grip force contact guard.
`ifndef GRIP_FORCE_CONTACT_GUARD_ASSERT_SVH
`define GRIP_FORCE_CONTACT_GUARD_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GFCG_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grip_force_contact_guard: assertion failed");
// next-cycle implication
`define GFCG_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grip_force_contact_guard: assertion failed");
`else
`define GFCG_ASSERT_IMP(name, clk, rst, ante, cons)
`define GFCG_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/gfcg_pkg.sv -----
// Shared types, constants and functions for the grip force contact guard.
package gfcg_pkg;

   localparam int NUM_ACTUATORS_DEF = 12;
   localparam int POS_BITS_DEF      = 16;

   localparam int ACT_W     = 4;
   localparam int WORD_W    = 16;
   localparam int LIMIT_W   = 10;
   localparam int MARGIN_W  = 13;
   localparam int BACKOFF_W = 14;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_MIN = 10'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = 10'd1000;

   localparam logic [LIMIT_W-1:0]   RST_DEFAULT_FORCE = 10'd100;
   localparam logic [LIMIT_W-1:0]   RST_CLOSING_SPEED = 10'd25;
   localparam logic [LIMIT_W-1:0]   RST_OPENING_SPEED = 10'd1000;
   localparam logic [MARGIN_W-1:0]  RST_DIR_MARGIN    = 13'd66;
   localparam logic [BACKOFF_W-1:0] RST_CONTACT_BACK  = 14'd655;
   localparam logic [BACKOFF_W-1:0] RST_SEVERE_BACK   = 14'd1638;

   typedef enum logic [2:0] {
      REG_DEFAULT_FORCE = 3'd0,
      REG_CLOSING_SPEED = 3'd1,
      REG_OPENING_SPEED = 3'd2,
      REG_DIR_MARGIN    = 3'd3,
      REG_CONTACT_BACK  = 3'd4,
      REG_SEVERE_BACK   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]   default_force_limit;
      logic [LIMIT_W-1:0]   closing_speed;
      logic [LIMIT_W-1:0]   opening_speed;
      logic [MARGIN_W-1:0]  direction_margin;
      logic [BACKOFF_W-1:0] contact_backoff;
      logic [BACKOFF_W-1:0] severe_backoff;
   } cfg_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic logic [LIMIT_W-1:0] clamp_limit(input logic [WORD_W-1:0] v);
      logic [LIMIT_W-1:0] r;
      if (v < WORD_W'(LIMIT_MIN)) begin
         r = LIMIT_MIN;
      end else if (v > WORD_W'(LIMIT_MAX)) begin
         r = LIMIT_MAX;
      end else begin
         r = v[LIMIT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/gfcg_csr.sv -----
// Configuration register file behind the APB-style port.
module gfcg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gfcg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gfcg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gfcg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output gfcg_pkg::cfg_type                 cfg
);
   import gfcg_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type reg_sel;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_DEFAULT_FORCE: cfg_in.default_force_limit = csr_pwdata[LIMIT_W-1:0];
            REG_CLOSING_SPEED: cfg_in.closing_speed       = csr_pwdata[LIMIT_W-1:0];
            REG_OPENING_SPEED: cfg_in.opening_speed       = csr_pwdata[LIMIT_W-1:0];
            REG_DIR_MARGIN:    cfg_in.direction_margin    = csr_pwdata[MARGIN_W-1:0];
            REG_CONTACT_BACK:  cfg_in.contact_backoff     = csr_pwdata[BACKOFF_W-1:0];
            REG_SEVERE_BACK:   cfg_in.severe_backoff      = csr_pwdata[BACKOFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_force_limit <= RST_DEFAULT_FORCE;
         cfg_ff.closing_speed       <= RST_CLOSING_SPEED;
         cfg_ff.opening_speed       <= RST_OPENING_SPEED;
         cfg_ff.direction_margin    <= RST_DIR_MARGIN;
         cfg_ff.contact_backoff     <= RST_CONTACT_BACK;
         cfg_ff.severe_backoff      <= RST_SEVERE_BACK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEFAULT_FORCE: csr_prdata = CSR_DATA_W'(cfg_ff.default_force_limit);
         REG_CLOSING_SPEED: csr_prdata = CSR_DATA_W'(cfg_ff.closing_speed);
         REG_OPENING_SPEED: csr_prdata = CSR_DATA_W'(cfg_ff.opening_speed);
         REG_DIR_MARGIN:    csr_prdata = CSR_DATA_W'(cfg_ff.direction_margin);
         REG_CONTACT_BACK:  csr_prdata = CSR_DATA_W'(cfg_ff.contact_backoff);
         REG_SEVERE_BACK:   csr_prdata = CSR_DATA_W'(cfg_ff.severe_backoff);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// ----- rtl/gfcg_state_mem.sv -----
// Per-actuator contact state memory: valid bits, registered read, write forwarding.
module gfcg_state_mem #(
   parameter int DEPTH    = gfcg_pkg::NUM_ACTUATORS_DEF,
   parameter int POS_BITS = gfcg_pkg::POS_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     rd_en,
   input  logic [gfcg_pkg::addr_width(DEPTH)-1:0]   rd_addr,
   output logic                                     rd_latch,
   output logic [POS_BITS-1:0]                      rd_hold,
   input  logic                                     wr_en,
   input  logic [gfcg_pkg::addr_width(DEPTH)-1:0]   wr_addr,
   input  logic                                     wr_latch,
   input  logic [POS_BITS-1:0]                      wr_hold
);
   import gfcg_pkg::*;

   localparam int ADDR_W = addr_width(DEPTH);
   localparam logic [POS_BITS-1:0] POS_ONE = {1'b1, {(POS_BITS-1){1'b0}}};

   logic [POS_BITS:0]   mem_ff [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [POS_BITS:0]   rd_data_ff;
   logic                rd_valid_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic                fwd_valid_ff;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   logic [POS_BITS:0]   fwd_data_ff;
   logic [POS_BITS:0]   entry;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_latch, wr_hold};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= {wr_latch, wr_hold};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
            fwd_valid_ff      <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // newest write to the same entry wins over the array read
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) begin
         entry = fwd_data_ff;
      end else if (rd_valid_ff) begin
         entry = rd_data_ff;
      end else begin
         entry = {1'b0, POS_ONE};
      end
   end

   assign rd_latch = entry[POS_BITS];
   assign rd_hold  = entry[POS_BITS-1:0];

endmodule

// ----- rtl/gfcg_core.sv -----
// Limit selection and safe target computation for one transaction.
module gfcg_core #(
   parameter int POS_BITS = gfcg_pkg::POS_BITS_DEF
) (
   input  gfcg_pkg::cfg_type                  cfg,
   input  logic [POS_BITS-1:0]                requested_position,
   input  logic [POS_BITS-1:0]                measured_position,
   input  logic [gfcg_pkg::WORD_W-1:0]        sensed_force,
   input  logic                               position_ok,
   input  logic                               force_ok,
   input  logic                               extended_mode,
   input  logic [gfcg_pkg::WORD_W-1:0]        speed_request,
   input  logic [gfcg_pkg::WORD_W-1:0]        force_request,
   input  logic                               latch_cur,
   input  logic [POS_BITS-1:0]                hold_cur,
   output logic                               opening,
   output logic                               latch_new,
   output logic [POS_BITS-1:0]                hold_new,
   output logic [POS_BITS-1:0]                safe_position,
   output logic [gfcg_pkg::LIMIT_W-1:0]       speed_limit,
   output logic [gfcg_pkg::LIMIT_W-1:0]       force_limit
);
   import gfcg_pkg::*;

   localparam int SUM_W = ((POS_BITS > BACKOFF_W) ? POS_BITS : BACKOFF_W) + 1;
   localparam logic [POS_BITS-1:0] POS_ONE = {1'b1, {(POS_BITS-1){1'b0}}};

   logic [POS_BITS-1:0] req_cap;
   logic [POS_BITS-1:0] meas_cap;
   logic [SUM_W-1:0]    open_sum;
   logic [WORD_W-1:0]   speed_pick;
   logic [WORD_W-1:0]   force_pick;
   logic [11:0]         limit_x3;
   logic                force_hit;
   logic                severe;
   logic [BACKOFF_W-1:0] backoff;
   logic [SUM_W-1:0]    hold_sum;
   logic [POS_BITS-1:0] hold_calc;

   assign req_cap  = (requested_position > POS_ONE) ? POS_ONE : requested_position;
   assign meas_cap = (measured_position > POS_ONE) ? POS_ONE : measured_position;
   assign open_sum = SUM_W'(req_cap) + SUM_W'(cfg.direction_margin);
   assign opening  = open_sum >= SUM_W'(measured_position);

   always_comb begin
      if (extended_mode && (speed_request != '0)) begin
         speed_pick = speed_request;
      end else if (opening) begin
         speed_pick = WORD_W'(cfg.opening_speed);
      end else begin
         speed_pick = WORD_W'(cfg.closing_speed);
      end
      if (extended_mode && (force_request != '0)) begin
         force_pick = force_request;
      end else begin
         force_pick = WORD_W'(cfg.default_force_limit);
      end
   end

   assign speed_limit = clamp_limit(speed_pick);
   assign force_limit = clamp_limit(force_pick);

   assign limit_x3  = 12'({force_limit, 1'b0}) + 12'(force_limit);
   assign force_hit = sensed_force >= WORD_W'(force_limit);
   assign severe    = {1'b0, sensed_force, 1'b0} >= 18'(limit_x3);
   assign backoff   = severe ? cfg.severe_backoff : cfg.contact_backoff;
   assign hold_sum  = SUM_W'(measured_position) + SUM_W'(backoff);
   assign hold_calc = (hold_sum > SUM_W'(POS_ONE)) ? POS_ONE : hold_sum[POS_BITS-1:0];

   always_comb begin
      latch_new     = latch_cur;
      hold_new      = hold_cur;
      safe_position = req_cap;
      if (opening) begin
         latch_new     = 1'b0;
         safe_position = req_cap;
      end else if (!position_ok || !force_ok) begin
         safe_position = meas_cap;
      end else begin
         if (!latch_cur && force_hit) begin
            latch_new = 1'b1;
            hold_new  = hold_calc;
         end
         safe_position = latch_new ? hold_new : req_cap;
      end
   end

endmodule

// ----- rtl/grip_force_contact_guard.sv -----
// Top level of the grip force contact guard.
//
//   port group   dir   handshake          carries
//   req_*        in    tvalid / tready    one control tick for one actuator
//   rsp_*        out   tvalid / tready    safe target, speed and force limits, contact
//   csr_*        in    APB write / read   six configuration registers
//
// One transaction per cycle sustained while rsp_tready keeps up; a taken request is
// registered in the compute stage and then in the response register behind rsp_tvalid.
// The state memory is read when a request is taken and written when it leaves the
// compute stage; a same-actuator follow-on gets the entry through the forward register.
// Reset is synchronous; valid bits make every actuator read as unlatched and fully open.
// A stalled response holds the compute stage; the request side keeps flowing otherwise.
module grip_force_contact_guard #(
   parameter int NUM_ACTUATORS = gfcg_pkg::NUM_ACTUATORS_DEF,
   parameter int POS_BITS      = gfcg_pkg::POS_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // actuator, requested_position, measured_position, sensed force,
   // speed_request, force_request
   input  logic [((52+2*POS_BITS+7)/8)*8-1:0]     req_tdata,
   // position_ok, force_ok, extended_mode
   input  logic [2:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // safe_position, speed_limit, force_limit
   output logic [((POS_BITS+20+7)/8)*8-1:0]       rsp_tdata,
   // contact_flag
   output logic [0:0]                             rsp_tuser,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [gfcg_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [gfcg_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [gfcg_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import gfcg_pkg::*;

`include "grip_force_contact_guard_assert.svh"

   localparam int ADDR_W     = addr_width(NUM_ACTUATORS);
   localparam int RSP_DATA_W = ((POS_BITS+20+7)/8)*8;
   localparam int OFF_REQ    = ACT_W;
   localparam int OFF_MEAS   = OFF_REQ + POS_BITS;
   localparam int OFF_FORCE  = OFF_MEAS + POS_BITS;
   localparam int OFF_SPD    = OFF_FORCE + WORD_W;
   localparam int OFF_FRQ    = OFF_SPD + WORD_W;
   localparam logic [POS_BITS-1:0] POS_ONE = {1'b1, {(POS_BITS-1){1'b0}}};

   cfg_type cfg;

   logic                  req_accept;
   logic                  s1_adv;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [ACT_W-1:0]      s1_act_ff;
   logic [POS_BITS-1:0]   s1_req_ff;
   logic [POS_BITS-1:0]   s1_meas_ff;
   logic [WORD_W-1:0]     s1_force_ff;
   logic                  s1_pos_ok_ff;
   logic                  s1_force_ok_ff;
   logic                  s1_ext_ff;
   logic [WORD_W-1:0]     s1_spd_req_ff;
   logic [WORD_W-1:0]     s1_frc_req_ff;
   logic                  s1_in_range;

   logic                  mem_latch;
   logic [POS_BITS-1:0]   mem_hold;
   logic                  latch_cur;
   logic [POS_BITS-1:0]   hold_cur;

   logic                  core_opening;
   logic                  core_latch;
   logic [POS_BITS-1:0]   core_hold;
   logic [POS_BITS-1:0]   core_safe;
   logic [LIMIT_W-1:0]    core_speed;
   logic [LIMIT_W-1:0]    core_force;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [POS_BITS-1:0]   rsp_safe_ff;
   logic [LIMIT_W-1:0]    rsp_speed_ff;
   logic [LIMIT_W-1:0]    rsp_force_ff;
   logic                  rsp_contact_ff;
   logic                  rsp_limits_ok;

   gfcg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign req_accept  = req_tvalid && req_tready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_act_ff      <= req_tdata[ACT_W-1:0];
         s1_req_ff      <= req_tdata[OFF_REQ +: POS_BITS];
         s1_meas_ff     <= req_tdata[OFF_MEAS +: POS_BITS];
         s1_force_ff    <= req_tdata[OFF_FORCE +: WORD_W];
         s1_spd_req_ff  <= req_tdata[OFF_SPD +: WORD_W];
         s1_frc_req_ff  <= req_tdata[OFF_FRQ +: WORD_W];
         s1_pos_ok_ff   <= req_tuser[0];
         s1_force_ok_ff <= req_tuser[1];
         s1_ext_ff      <= req_tuser[2];
      end
   end

   gfcg_state_mem #(
      .DEPTH    (NUM_ACTUATORS),
      .POS_BITS (POS_BITS)
   ) u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (ADDR_W'(req_tdata[ACT_W-1:0])),
      .rd_latch (mem_latch),
      .rd_hold  (mem_hold),
      .wr_en    (s1_adv && s1_in_range),
      .wr_addr  (ADDR_W'(s1_act_ff)),
      .wr_latch (core_latch),
      .wr_hold  (core_hold)
   );

   assign s1_in_range = 32'(s1_act_ff) < NUM_ACTUATORS;
   assign latch_cur   = s1_in_range ? mem_latch : 1'b0;
   assign hold_cur    = s1_in_range ? mem_hold : POS_ONE;

   gfcg_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .cfg                (cfg),
      .requested_position (s1_req_ff),
      .measured_position  (s1_meas_ff),
      .sensed_force       (s1_force_ff),
      .position_ok        (s1_pos_ok_ff),
      .force_ok           (s1_force_ok_ff),
      .extended_mode      (s1_ext_ff),
      .speed_request      (s1_spd_req_ff),
      .force_request      (s1_frc_req_ff),
      .latch_cur          (latch_cur),
      .hold_cur           (hold_cur),
      .opening            (core_opening),
      .latch_new          (core_latch),
      .hold_new           (core_hold),
      .safe_position      (core_safe),
      .speed_limit        (core_speed),
      .force_limit        (core_force)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_safe_ff    <= core_safe;
         rsp_speed_ff   <= core_speed;
         rsp_force_ff   <= core_force;
         rsp_contact_ff <= s1_in_range && core_latch;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_DATA_W'({rsp_force_ff, rsp_speed_ff, rsp_safe_ff});
   assign rsp_tuser[0] = rsp_contact_ff;

   assign rsp_limits_ok = (rsp_speed_ff >= LIMIT_MIN) && (rsp_speed_ff <= LIMIT_MAX) &&
                          (rsp_force_ff >= LIMIT_MIN) && (rsp_force_ff <= LIMIT_MAX);

   `GFCG_ASSERT_NXT(a_adv_fills_output, clock, reset, s1_adv, rsp_valid_ff)
   `GFCG_ASSERT_IMP(a_safe_capped, clock, reset, rsp_valid_ff, rsp_safe_ff <= POS_ONE)
   `GFCG_ASSERT_IMP(a_limits_in_range, clock, reset, rsp_valid_ff, rsp_limits_ok)
   `GFCG_ASSERT_NXT(a_open_clears_contact, clock, reset, s1_adv && core_opening, !rsp_contact_ff)

endmodule
